// File: rtl/core/vnf_pkg.sv
// ----------------------------------------------------------------------------
// vnf_pkg
// Shared types, constants and small tables for the value-noise height block.
// ----------------------------------------------------------------------------
`default_nettype none

package vnf_pkg;

  localparam int MAX_OCT   = 8;    // octave lanes
  localparam int OCT_IDX_W = 3;    // bits of an octave index
  localparam int OCT_CNT_W = 4;    // bits of the octave count register
  localparam int GRID_W    = 10;   // column / row width
  localparam int INV_W     = 17;   // inv_scale width
  localparam int AMP_W     = 24;   // amplitude width
  localparam int PX_W      = GRID_W + INV_W;   // coordinate before octave shift
  localparam int COORD_W   = PX_W + MAX_OCT - 1;
  localparam int FRAC_W    = 16;
  localparam int NOISE_W   = 18;   // signed corner / octave noise value
  localparam int ACC_W     = 25;   // signed weighted octave sum
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [31:0] HASH_X    = 32'd374761393;
  localparam logic [31:0] HASH_Y    = 32'd668265263;
  localparam logic [31:0] HASH_MIX0 = 32'd3284157443;
  localparam logic [31:0] HASH_MIX1 = 32'd1274126177;
  localparam logic [31:0] SEED_STEP = 32'd31337;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OCT_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADDITIVE  = 3'd4;

  // stage count: input, coordinate, 6 lane stages, 6 combine stages, output
  localparam int PIPE_LEN = 15;

  typedef struct packed {
    logic [INV_W-1:0]     inv_scale;
    logic [AMP_W-1:0]     amplitude;
    logic [OCT_CNT_W-1:0] octave_count;
    logic [31:0]          noise_seed;
    logic                 additive_mode;
  } cfg_t;

  // octave count clamped to 1..MAX_OCT
  function automatic logic [OCT_CNT_W-1:0] eff_octaves(input logic [OCT_CNT_W-1:0] k);
    logic [OCT_CNT_W-1:0] r;
    r = k;
    if (k == '0) r = OCT_CNT_W'(1);
    else if (k > OCT_CNT_W'(MAX_OCT)) r = OCT_CNT_W'(MAX_OCT);
    return r;
  endfunction

  // total weight 2^k - 1
  function automatic logic [7:0] weight_sum(input logic [OCT_CNT_W-1:0] k);
    return 8'((9'd1 << k) - 9'd1);
  endfunction

  // floor(2^31 / (2^k - 1))
  function automatic logic [31:0] weight_recip(input logic [OCT_CNT_W-1:0] k);
    logic [31:0] r;
    r = 32'd2147483648;
    unique case (k)
      4'd2:    r = 32'd715827882;
      4'd3:    r = 32'd306783378;
      4'd4:    r = 32'd143165576;
      4'd5:    r = 32'd69273666;
      4'd6:    r = 32'd34087042;
      4'd7:    r = 32'd16909320;
      4'd8:    r = 32'd8421504;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/vnf_if.sv
// ----------------------------------------------------------------------------
// vnf_if
// Valid/ready channels for grid samples in and heights out.
// ----------------------------------------------------------------------------
`default_nettype none

interface vnf_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  column;
  logic [9:0]  row;
  logic signed [31:0] old_height;
  modport source(output valid, column, row, old_height, input ready);
  modport sink(input valid, column, row, old_height, output ready);
endinterface

interface vnf_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] new_height;
  modport source(output valid, new_height, input ready);
  modport sink(input valid, new_height, output ready);
endinterface

`default_nettype wire

// File: rtl/core/vnf_octave.sv
// ----------------------------------------------------------------------------
// vnf_octave
// One octave lane: lattice hash of four corners, smoothstep, bilinear blend.
// ----------------------------------------------------------------------------
`default_nettype none

module vnf_octave (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [vnf_pkg::OCT_IDX_W-1:0]   octave_idx,
  input  wire logic [31:0]                     seed,
  input  wire logic [vnf_pkg::PX_W-1:0]        px,
  input  wire logic [vnf_pkg::PX_W-1:0]        py,
  output logic signed [vnf_pkg::NOISE_W-1:0]   noise
);

  localparam int FW = vnf_pkg::FRAC_W;
  localparam int CW = vnf_pkg::COORD_W;
  localparam int NW = vnf_pkg::NOISE_W;

  logic [CW-1:0] x, y;
  logic [31:0]   ix, iy;

  // stage 1
  logic [31:0]   cxa0_r, cxa1_r, cyb0_r, cyb1_r;
  logic [31:0]   f2x_r, f2y_r;
  logic [FW-1:0] fx_r, fy_r;
  logic [31:0]   seed_r;
  // stage 2
  logic [31:0]   h_r [4];
  logic [FW:0]   sx_r, sy_r;
  // stage 3
  logic [31:0]   g_r [4];
  logic [FW:0]   sx3_r, sy3_r;
  // stage 4
  logic signed [NW-1:0] c_r [4];
  logic [FW:0]   sx4_r, sy4_r;
  // stage 5
  logic signed [NW-1:0] a_r, b_r;
  logic [FW:0]   sy5_r;
  // stage 6
  logic signed [NW-1:0] n_r;

  logic [31:0]   h_nxt [4];
  logic [31:0]   g_nxt [4];
  logic signed [NW-1:0] c_nxt [4];
  logic [FW:0]   sx_nxt, sy_nxt;
  logic signed [NW-1:0] a_nxt, b_nxt, n_nxt;

  assign x  = CW'(px) << octave_idx;
  assign y  = CW'(py) << octave_idx;
  assign ix = 32'(x[CW-1:FW]);
  assign iy = 32'(y[CW-1:FW]);

  // q1.16 smoothstep from the registered square
  function automatic logic [FW:0] fade(input logic [31:0] f2, input logic [FW-1:0] f);
    logic [FW+1:0]  w;
    logic [2*FW+1:0] p;
    w = 18'd196608 - {1'b0, f, 1'b0};
    p = f2[31:FW] * w;
    return (FW+1)'(p >> FW);
  endfunction

  function automatic logic signed [NW-1:0] blend(input logic signed [NW-1:0] lo,
                                                 input logic signed [NW-1:0] hi,
                                                 input logic [FW:0] s);
    logic signed [NW:0]      d;
    logic signed [NW+FW+1:0] p;
    d = (NW+1)'(hi) - (NW+1)'(lo);
    p = d * $signed({1'b0, s});
    return lo + NW'(p >>> FW);
  endfunction

  always_comb begin
    h_nxt[0] = ((seed_r + cxa0_r) ^ cyb0_r) * vnf_pkg::HASH_MIX0;
    h_nxt[1] = ((seed_r + cxa1_r) ^ cyb0_r) * vnf_pkg::HASH_MIX0;
    h_nxt[2] = ((seed_r + cxa0_r) ^ cyb1_r) * vnf_pkg::HASH_MIX0;
    h_nxt[3] = ((seed_r + cxa1_r) ^ cyb1_r) * vnf_pkg::HASH_MIX0;
    for (int i = 0; i < 4; i++) begin
      g_nxt[i] = (h_r[i] ^ (h_r[i] >> 13)) * vnf_pkg::HASH_MIX1;
      c_nxt[i] = $signed(NW'((g_r[i] ^ (g_r[i] >> 16)) >> 15)) - NW'(65536);
    end
    sx_nxt = fade(f2x_r, fx_r);
    sy_nxt = fade(f2y_r, fy_r);
    a_nxt  = blend(c_r[0], c_r[1], sx4_r);
    b_nxt  = blend(c_r[2], c_r[3], sx4_r);
    n_nxt  = blend(a_r, b_r, sy5_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cxa0_r <= ix * vnf_pkg::HASH_X;
      cxa1_r <= (ix + 32'd1) * vnf_pkg::HASH_X;
      cyb0_r <= iy * vnf_pkg::HASH_Y;
      cyb1_r <= (iy + 32'd1) * vnf_pkg::HASH_Y;
      f2x_r  <= x[FW-1:0] * x[FW-1:0];
      f2y_r  <= y[FW-1:0] * y[FW-1:0];
      fx_r   <= x[FW-1:0];
      fy_r   <= y[FW-1:0];
      seed_r <= seed;
      h_r    <= h_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      g_r    <= g_nxt;
      sx3_r  <= sx_r;
      sy3_r  <= sy_r;
      c_r    <= c_nxt;
      sx4_r  <= sx3_r;
      sy4_r  <= sy3_r;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      sy5_r  <= sy4_r;
      n_r    <= n_nxt;
    end
  end

  assign noise = n_r;

endmodule

`default_nettype wire

// File: rtl/core/vnf_combine.sv
// ----------------------------------------------------------------------------
// vnf_combine
// Weighted octave sum, normalization by the total weight, amplitude scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module vnf_combine (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire vnf_pkg::cfg_t                       cfg,
  input  wire logic signed [vnf_pkg::NOISE_W-1:0]  noise [vnf_pkg::MAX_OCT],
  output logic signed [vnf_pkg::NOISE_W+vnf_pkg::AMP_W:0] scaled
);

  localparam int NO = vnf_pkg::MAX_OCT;
  localparam int AW = vnf_pkg::ACC_W;
  localparam int NP = (NO + 1) / 2;
  localparam int NW = vnf_pkg::NOISE_W;
  localparam int SW = NW + vnf_pkg::AMP_W + 1;

  logic [vnf_pkg::OCT_CNT_W-1:0] k;
  logic [7:0]  dsum;
  logic signed [AW-1:0] w [NO];
  logic signed [AW-1:0] tot;

  logic signed [AW-1:0] pair_r [NP];
  logic [AW-1:0] m_r, m3_r, m4_r;
  logic          neg_r, neg3_r, neg4_r;
  logic [AW+31:0] prod_r;
  logic [AW-1:0] q0_r;
  logic [AW+7:0] t_r;
  logic signed [NW-1:0] norm_r;
  logic signed [SW-1:0] scaled_r;

  logic [AW-1:0] q0_nxt, q_nxt;
  logic [AW+7:0] r_nxt;

  assign k    = vnf_pkg::eff_octaves(cfg.octave_count);
  assign dsum = vnf_pkg::weight_sum(k);

  // octave o weighs 2^(k-1-o); octaves beyond the count drop out
  always_comb begin
    for (int o = 0; o < NO; o++) begin
      if (vnf_pkg::OCT_CNT_W'(o) < k)
        w[o] = AW'(noise[o]) <<< (k - vnf_pkg::OCT_CNT_W'(o) - vnf_pkg::OCT_CNT_W'(1));
      else
        w[o] = '0;
    end
    tot = '0;
    for (int p = 0; p < NP; p++) tot = tot + pair_r[p];
    q0_nxt = AW'(prod_r >> 31);
    r_nxt  = {8'd0, m4_r} - t_r;
    q_nxt  = (r_nxt >= (AW+8)'(dsum)) ? q0_r + AW'(1) : q0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < NP; p++)
        pair_r[p] <= w[2*p] + ((2*p + 1 < NO) ? w[(2*p + 1) % NO] : AW'(0));
      neg_r    <= tot[AW-1];
      m_r      <= tot[AW-1] ? AW'(-tot) : AW'(tot);
      prod_r   <= m_r * vnf_pkg::weight_recip(k);
      m3_r     <= m_r;
      neg3_r   <= neg_r;
      q0_r     <= q0_nxt;
      t_r      <= q0_nxt * dsum;
      m4_r     <= m3_r;
      neg4_r   <= neg3_r;
      norm_r   <= neg4_r ? -NW'(q_nxt) : NW'(q_nxt);
      scaled_r <= norm_r * $signed({1'b0, cfg.amplitude});
    end
  end

  assign scaled = scaled_r;

endmodule

`default_nettype wire

// File: rtl/core/value_noise_fbm_height_top.sv
// ----------------------------------------------------------------------------
// value_noise_fbm_height_top
// Fractal value-noise heightmap sample, signed Q16.16, one sample per cycle while out_bus is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries a grid point (column, row) and its old height; out_bus
//   returns the new height, noise alone or noise plus old height in additive
//   mode. Both are valid/ready channels; a beat moves when both are high.
//   cfg_we/cfg_index/cfg_data write one register per cycle (0 inv_scale,
//   1 amplitude, 2 octave_count, 3 noise_seed, 4 additive_mode); write only
//   while no sample is in flight.
//   Throughput is one sample per cycle while out_bus is not stalled:
//   every octave has its own hash lane and all stages advance together,
//   so the lane multipliers and the normalizing divide-by-reciprocal set
//   the stage count, not the rate.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   register defaults. When the receiver stalls with a result waiting, the
//   whole pipeline holds and in_bus.ready drops in the same cycle; nothing
//   is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module value_noise_fbm_height_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  vnf_in_if.sink                                 in_bus,
  vnf_out_if.source                              out_bus,
  input  wire logic                              cfg_we,
  input  wire logic [vnf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vnf_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int LAST = vnf_pkg::PIPE_LEN - 1;
  localparam int NO   = vnf_pkg::MAX_OCT;
  localparam int SW   = vnf_pkg::NOISE_W + vnf_pkg::AMP_W + 1;

  vnf_pkg::cfg_t cfg_r;
  logic [vnf_pkg::PIPE_LEN-1:0] v_r;
  logic en;

  logic [vnf_pkg::GRID_W-1:0] col_r, row_r;
  logic [vnf_pkg::PX_W-1:0]   px_r, py_r;
  logic signed [31:0]         old_r [LAST];
  logic signed [31:0]         res_r;
  logic signed [31:0]         res_nxt;

  logic signed [vnf_pkg::NOISE_W-1:0] lane_n [NO];
  logic signed [SW-1:0] scaled;
  logic signed [SW-1:0] height;

  // whole pipe advances unless a finished beat is stuck at the output
  assign en           = !v_r[LAST] || out_bus.ready;
  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_scale     <= 17'd655;
      cfg_r.amplitude     <= 24'd655360;
      cfg_r.octave_count  <= 4'd4;
      cfg_r.noise_seed    <= 32'd0;
      cfg_r.additive_mode <= 1'b0;
      v_r                 <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          vnf_pkg::REG_INV_SCALE: cfg_r.inv_scale     <= cfg_data[vnf_pkg::INV_W-1:0];
          vnf_pkg::REG_AMPLITUDE: cfg_r.amplitude     <= cfg_data[vnf_pkg::AMP_W-1:0];
          vnf_pkg::REG_OCT_COUNT: cfg_r.octave_count  <= cfg_data[vnf_pkg::OCT_CNT_W-1:0];
          vnf_pkg::REG_SEED:      cfg_r.noise_seed    <= cfg_data;
          vnf_pkg::REG_ADDITIVE:  cfg_r.additive_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (en) v_r <= {v_r[LAST-1:0], in_bus.valid};
    end
  end

  assign height  = scaled >>> vnf_pkg::FRAC_W;
  assign res_nxt = cfg_r.additive_mode ? old_r[LAST-1] + height[31:0] : height[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      col_r    <= in_bus.column;
      row_r    <= in_bus.row;
      old_r[0] <= in_bus.old_height;
      for (int i = 1; i < LAST; i++) old_r[i] <= old_r[i-1];
      px_r     <= col_r * cfg_r.inv_scale;
      py_r     <= row_r * cfg_r.inv_scale;
      res_r    <= res_nxt;
    end
  end

  for (genvar o = 0; o < NO; o++) begin : g_lane
    vnf_octave u_oct (
      .clk        (clk),
      .en         (en),
      .octave_idx (vnf_pkg::OCT_IDX_W'(o)),
      .seed       (cfg_r.noise_seed + 32'(o) * vnf_pkg::SEED_STEP),
      .px         (px_r),
      .py         (py_r),
      .noise      (lane_n[o])
    );
  end

  vnf_combine u_comb (
    .clk    (clk),
    .en     (en),
    .cfg    (cfg_r),
    .noise  (lane_n),
    .scaled (scaled)
  );

  assign out_bus.valid      = v_r[LAST];
  assign out_bus.new_height = res_r;

`ifndef SYNTH
  // pipeline comes up empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> v_r == '0)
    else $error("pipeline not empty after reset");
  // a stalled pipe keeps every valid bit in place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && !cfg_we) |=> $stable(v_r))
    else $error("valid bits moved during stall");
  // accepted beat enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> v_r[0])
    else $error("accepted beat lost");
`endif

endmodule

`default_nettype wire

// File: verif/value_noise_fbm_height_top_test.sv
// ----------------------------------------------------------------------------
// value_noise_fbm_height_top_test
// Drives grid samples through the value-noise height block under random
// source gaps and sink stalls, across several register settings, and checks
// every height against a local fixed-point noise predictor.
// ----------------------------------------------------------------------------
`default_nettype none

class height_scoreboard;
  logic [16:0] inv_scale;
  logic [23:0] amplitude;
  logic [3:0]  octave_count;
  logic [31:0] noise_seed;
  logic        additive_mode;
  logic [31:0] pending_heights[$];
  int          mismatch_count;

  function new();
    inv_scale = 17'd655;
    amplitude = 24'd655360;
    octave_count = 4'd4;
    noise_seed = 32'd0;
    additive_mode = 1'b0;
    mismatch_count = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      vnf_pkg::REG_INV_SCALE: inv_scale = data[16:0];
      vnf_pkg::REG_AMPLITUDE: amplitude = data[23:0];
      vnf_pkg::REG_OCT_COUNT: octave_count = data[3:0];
      vnf_pkg::REG_SEED:      noise_seed = data;
      vnf_pkg::REG_ADDITIVE:  additive_mode = data[0];
      default: ;
    endcase
  endfunction

  function longint asr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function longint lattice_value(logic [31:0] cx, logic [31:0] cy, logic [31:0] seed);
    logic [31:0] h;
    h = ((seed + cx * vnf_pkg::HASH_X) ^ (cy * vnf_pkg::HASH_Y)) * vnf_pkg::HASH_MIX0;
    h = (h ^ (h >> 13)) * vnf_pkg::HASH_MIX1;
    h = h ^ (h >> 16);
    return longint'({15'd0, h[31:15]}) - 65536;
  endfunction

  function longint smooth_weight(longint f);
    longint f2;
    f2 = (f * f) >>> 16;
    return (f2 * ((3 << 16) - 2 * f)) >>> 16;
  endfunction

  function longint mix(longint a, longint b, longint s);
    return a + asr_floor((b - a) * s, 16);
  endfunction

  function logic [31:0] noise_height(logic [9:0] col, logic [9:0] row, logic [31:0] old);
    int k;
    longint acc, norm, hgt, sx, sy, top, bot, x, y;
    logic [31:0] ix, iy, seed, res;
    k = octave_count;
    if (k < 1) k = 1;
    if (k > 8) k = 8;
    acc = 0;
    for (int o = 0; o < k; o++) begin
      x = (longint'(col) * longint'(inv_scale)) << o;
      y = (longint'(row) * longint'(inv_scale)) << o;
      ix = x[47:16];
      iy = y[47:16];
      seed = noise_seed + o * vnf_pkg::SEED_STEP;
      sx = smooth_weight(x & 64'hFFFF);
      sy = smooth_weight(y & 64'hFFFF);
      top = mix(lattice_value(ix, iy, seed), lattice_value(ix + 1, iy, seed), sx);
      bot = mix(lattice_value(ix, iy + 1, seed), lattice_value(ix + 1, iy + 1, seed), sx);
      acc += mix(top, bot, sy) * (longint'(1) << (k - 1 - o));
    end
    norm = acc / ((longint'(1) << k) - 1);
    hgt = asr_floor(norm * longint'(amplitude), 16);
    res = hgt[31:0];
    if (additive_mode) res = old + res;
    return res;
  endfunction

  function void note_sample(logic [9:0] col, logic [9:0] row, logic [31:0] old);
    pending_heights.push_back(noise_height(col, row, old));
  endfunction

  function void check_height(logic [31:0] got);
    logic [31:0] want;
    if (pending_heights.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("unexpected height beat %h", got);
      return;
    end
    want = pending_heights.pop_front();
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("new_height mismatch: expected %h got %h", want, got);
    end
  endfunction
endclass

module value_noise_fbm_height_top_test;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  longint      cycle_count = 0;
  logic        sink_ready_en = 1'b1;
  int          stall_left = 0;
  height_scoreboard sb;

  vnf_in_if  in_bus();
  vnf_out_if out_bus();

  value_noise_fbm_height_top uut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.column = '0;
    in_bus.row = '0;
    in_bus.old_height = '0;
    out_bus.ready = 1'b0;
  end

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("[value_noise_fbm_height_top] ERROR");
      $finish;
    end
  end

  // sink side: check every accepted result beat, random stalls
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) sb.check_height(out_bus.new_height);
    if (!sink_ready_en) out_bus.ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      out_bus.ready <= 1'b1;
    end
  end

  // valid stays up between back-to-back beats, drops only for a gap
  task automatic send_sample(logic [9:0] col, logic [9:0] row, logic [31:0] old);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.column <= col;
    in_bus.row <= row;
    in_bus.old_height <= old;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_sample(col, row, old);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending_heights.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_samples(int n);
    for (int i = 0; i < n; i++)
      send_sample($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, field extremes
    send_sample(10'd0, 10'd0, 32'd0);
    send_sample(10'd1023, 10'd1023, 32'h7FFFFFFF);
    send_sample(10'd0, 10'd1023, 32'h80000000);
    send_sample(10'd1023, 10'd0, 32'hFFFFFFFF);
    drain();
    // additive with wrap, max amplitude, inverse scale of one, octaves 0
    write_reg(vnf_pkg::REG_ADDITIVE, 32'd1);
    write_reg(vnf_pkg::REG_AMPLITUDE, 32'hFFFFFF);
    write_reg(vnf_pkg::REG_INV_SCALE, 32'd65536);
    write_reg(vnf_pkg::REG_OCT_COUNT, 32'd0);
    write_reg(vnf_pkg::REG_SEED, 32'hFFFFFFFF);
    send_sample(10'd1023, 10'd1023, 32'h7FFFFFFF);
    send_sample(10'd5, 10'd7, 32'h80000000);
    send_sample(10'd512, 10'd3, 32'h12345678);
    drain();
    // octave count above the limit, inverse scale above one
    write_reg(vnf_pkg::REG_OCT_COUNT, 32'd15);
    write_reg(vnf_pkg::REG_INV_SCALE, 32'h1FFFF);
    send_sample(10'd1023, 10'd1, 32'hFFFFFFFF);
    send_sample(10'd333, 10'd777, 32'd0);
    drain();
    write_reg(vnf_pkg::REG_OCT_COUNT, 32'd8);
    write_reg(vnf_pkg::REG_AMPLITUDE, 32'd0);
    write_reg(vnf_pkg::REG_INV_SCALE, 32'd0);
    send_sample(10'd100, 10'd200, 32'hDEADBEEF);
    drain();

    // random phases over a spread of settings
    for (int p = 0; p < 8; p++) begin
      write_reg(vnf_pkg::REG_INV_SCALE, (p == 0) ? 32'd655 : $urandom_range(0, 131071));
      write_reg(vnf_pkg::REG_AMPLITUDE, (p == 1) ? 32'hFFFFFF : $urandom_range(0, 16777215));
      write_reg(vnf_pkg::REG_OCT_COUNT, (p == 2) ? 32'd1 : $urandom_range(0, 15));
      write_reg(vnf_pkg::REG_SEED, $urandom);
      write_reg(vnf_pkg::REG_ADDITIVE, p % 2);
      random_samples(40);
      drain();
    end

    // back-to-back with sink always ready
    sink_ready_en = 1'b0;
    for (int i = 0; i < 60; i++) begin
      in_bus.valid <= 1'b1;
      in_bus.column <= $urandom_range(0, 1023);
      in_bus.row <= $urandom_range(0, 1023);
      in_bus.old_height <= $urandom;
      do @(posedge clk); while (!in_bus.ready);
      sb.note_sample(in_bus.column, in_bus.row, in_bus.old_height);
    end
    sink_ready_en = 1'b1;
    drain();

    if (sb.mismatch_count == 0 && sb.pending_heights.size() == 0)
      $display("[value_noise_fbm_height_top] OK");
    else
      $display("[value_noise_fbm_height_top] ERROR");
    $finish;
  end
endmodule

`default_nettype wire
